// ----- design/eqrm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package eqrm_pkg;

    // Build-time constants
    localparam int SAMPLE_BITS     = 16;
    localparam int HISTORY_WINDOWS = 5;
    localparam int RATE_SCALE      = 6;

    // Fixed field widths
    localparam int FEAT_W = 19;
    localparam int BPM_W  = 11;
    localparam int BEAT_W = 6;
    localparam int RUN_W  = 4;
    localparam int WARM_W = 10;
    localparam int RATE_W = 8;
    localparam int FILL_W = 3;

    localparam int WIN_LEN  = 5;
    localparam int FEAT_MAX = (1 << FEAT_W) - 1;
    localparam int BPM_MAX  = (1 << BPM_W) - 1;
    localparam int BEAT_MAX = (1 << BEAT_W) - 1;
    localparam int RUN_MAX  = (1 << RUN_W) - 1;

    // Feature datapath: |terms| sum to at most 6 * 2^SAMPLE_BITS
    localparam int Y_W   = SAMPLE_BITS + 3;
    localparam int SAT_W = (Y_W > FEAT_W) ? Y_W : FEAT_W;
    localparam int TH_W  = FEAT_W + 4;

    // Rate history
    localparam int HIST_W  = (HISTORY_WINDOWS > 1) ? $clog2(HISTORY_WINDOWS) : 1;
    localparam int HSUM_W  = $clog2(BEAT_MAX * HISTORY_WINDOWS + 1);
    localparam int PROD_W  = HSUM_W + $clog2(RATE_SCALE + 1);
    localparam int BSAT_W  = (PROD_W > BPM_W) ? PROD_W : BPM_W;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Stream widths
    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 1 + FEAT_W + 1 + BPM_W + 1 + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LEN   = 2'd3;

    localparam logic [RATE_W-1:0] RATE_LOW_RST  = 8'd60;
    localparam logic [RATE_W-1:0] RATE_HIGH_RST = 8'd130;
    localparam logic [WARM_W-1:0] WARMUP_RST    = 10'd251;
    localparam logic [RUN_W-1:0]  RUN_LEN_RST   = 4'd4;

    typedef struct packed {
        logic [RATE_W-1:0] rate_low;
        logic [RATE_W-1:0] rate_high;
        logic [WARM_W-1:0] warmup_samples;
        logic [RUN_W-1:0]  run_length;
    } t_cfg;

    // One classified item on its way from front to back
    typedef struct packed {
        logic              tick;
        logic              calc;
        logic [FEAT_W-1:0] feat;
    } t_cmd;

    // Result, beat in the lowest bit
    typedef struct packed {
        logic              fast_flag;
        logic              slow_flag;
        logic [BPM_W-1:0]  rate_bpm;
        logic              rate_valid;
        logic [FEAT_W-1:0] feature;
        logic              beat;
    } t_result;

endpackage

`default_nettype wire

// ----- design/eqrm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module eqrm_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic                               i_kind,
    input  wire logic [eqrm_pkg::SAMPLE_BITS-1:0]   i_sample,
    output logic                                    o_cmd_valid,
    input  wire logic                               i_cmd_ready,
    output eqrm_pkg::t_cmd                          o_cmd
);
    import eqrm_pkg::*;

    // Four newest samples, r_win[3] the newest
    logic signed [SAMPLE_BITS-1:0] r_win [WIN_LEN-1];
    logic [FILL_W-1:0]             r_fill;
    logic [FILL_W-1:0]             n_fill;
    logic                          accept;
    logic                          filling;

    logic signed [Y_W-1:0] x0, x1, x2, x3, x4;
    logic signed [Y_W-1:0] d20, d31, d42, d2;
    logic [Y_W-1:0]        a20, a31, a42, a2;
    logic [Y_W-1:0]        y3;
    logic [SAT_W-1:0]      y3_ext;
    logic [FEAT_W-1:0]     feat;

    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;
    assign accept      = i_valid && i_cmd_ready;
    assign filling     = (r_fill < FILL_W'(WIN_LEN - 1));

    // Window after the shift: x0 oldest, x4 the incoming sample
    assign x0 = Y_W'(r_win[0]);
    assign x1 = Y_W'(r_win[1]);
    assign x2 = Y_W'(r_win[2]);
    assign x3 = Y_W'(r_win[3]);
    assign x4 = Y_W'($signed(i_sample));

    assign d20 = x2 - x0;
    assign d31 = x3 - x1;
    assign d42 = x4 - x2;
    assign d2  = x0 - (x2 <<< 1) + x4;

    assign a20 = d20[Y_W-1] ? Y_W'(-d20) : Y_W'(d20);
    assign a31 = d31[Y_W-1] ? Y_W'(-d31) : Y_W'(d31);
    assign a42 = d42[Y_W-1] ? Y_W'(-d42) : Y_W'(d42);
    assign a2  = d2[Y_W-1]  ? Y_W'(-d2)  : Y_W'(d2);

    assign y3     = a20 + (a31 << 1) + a42 + a2;
    assign y3_ext = SAT_W'(y3);
    assign feat   = (y3_ext > SAT_W'(FEAT_MAX)) ? FEAT_W'(FEAT_MAX) : FEAT_W'(y3);

    always_comb begin
        o_cmd  = '0;
        n_fill = r_fill;
        if (i_kind) begin
            o_cmd.tick = 1'b1;
        end else if (filling) begin
            n_fill = r_fill + FILL_W'(1);
        end else begin
            o_cmd.calc = 1'b1;
            o_cmd.feat = feat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
        end
    end

    // Shift on every accepted sample
    always_ff @(posedge i_clk) begin
        if (accept && !i_kind) begin
            for (int i = 0; i < WIN_LEN - 2; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WIN_LEN-2] <= $signed(i_sample);
        end
    end

endmodule

`default_nettype wire

// ----- design/eqrm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module eqrm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  eqrm_pkg::t_cmd      i_push_cmd,
    output logic                o_pop_valid,
    input  wire logic           i_pop_ready,
    output eqrm_pkg::t_cmd      o_pop_cmd
);
    import eqrm_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_rd_ptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- design/eqrm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module eqrm_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  eqrm_pkg::t_cfg      i_cfg,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_ready,
    input  eqrm_pkg::t_cmd      i_cmd,
    output logic                o_res_valid,
    input  wire logic           i_res_ready,
    output eqrm_pkg::t_result   o_res
);
    import eqrm_pkg::*;

    logic [FEAT_W-1:0]  r_peak,  n_peak;
    logic [WARM_W-1:0]  r_warm,  n_warm;
    logic               r_armed, n_armed;
    logic [RUN_W-1:0]   r_run,   n_run;
    logic [BEAT_W-1:0]  r_beats, n_beats;
    logic [BEAT_W-1:0]  r_hist [HISTORY_WINDOWS];
    logic [HIST_W-1:0]  r_hidx,  n_hidx;
    logic [HIST_W-1:0]  r_ticks, n_ticks;
    logic [HSUM_W-1:0]  r_hsum,  n_hsum;
    logic               r_out_valid;
    t_result            r_out,   n_out;

    logic               pop;
    logic               hist_we;
    logic [FEAT_W-1:0]  pk;
    logic               hit_lo;
    logic               hit_hi;
    logic [RUN_W-1:0]   run_t;
    logic               armed_t;
    logic [RUN_W-1:0]   need;
    logic [BSAT_W-1:0]  prod;
    logic [BPM_W-1:0]   bpm;

    assign o_cmd_ready = !r_out_valid || i_res_ready;
    assign pop         = i_cmd_valid && o_cmd_ready;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign need        = (i_cfg.run_length == '0) ? RUN_W'(1) : i_cfg.run_length;

    always_comb begin
        n_peak  = r_peak;
        n_warm  = r_warm;
        n_armed = r_armed;
        n_run   = r_run;
        n_beats = r_beats;
        n_hidx  = r_hidx;
        n_ticks = r_ticks;
        n_hsum  = r_hsum;
        n_out   = '0;
        hist_we = 1'b0;
        pk      = (i_cmd.feat > r_peak) ? i_cmd.feat : r_peak;
        hit_lo  = ((TH_W'(i_cmd.feat) << 3) + (TH_W'(i_cmd.feat) << 1)) >= TH_W'(pk);
        hit_hi  = ((TH_W'(i_cmd.feat) << 2) + TH_W'(i_cmd.feat)) >= (TH_W'(pk) << 2);
        run_t   = '0;
        armed_t = 1'b0;
        prod    = '0;
        bpm     = '0;

        if (i_cmd.tick) begin
            hist_we = 1'b1;
            n_beats = '0;
            n_hsum  = r_hsum - HSUM_W'(r_hist[r_hidx]) + HSUM_W'(r_beats);
            n_hidx  = (r_hidx == HIST_W'(HISTORY_WINDOWS - 1)) ? '0 : r_hidx + HIST_W'(1);
            if (r_ticks < HIST_W'(HISTORY_WINDOWS - 1)) begin
                n_ticks = r_ticks + HIST_W'(1);
            end else begin
                prod = BSAT_W'(n_hsum) * BSAT_W'(RATE_SCALE);
                bpm  = (prod > BSAT_W'(BPM_MAX)) ? BPM_W'(BPM_MAX) : BPM_W'(prod);
                n_out.rate_valid = 1'b1;
                n_out.rate_bpm   = bpm;
                if (bpm <= BPM_W'(i_cfg.rate_low)) begin
                    n_out.slow_flag = 1'b1;
                end else if (bpm >= BPM_W'(i_cfg.rate_high)) begin
                    n_out.fast_flag = 1'b1;
                end
            end
        end else if (i_cmd.calc) begin
            n_out.feature = i_cmd.feat;
            n_peak        = pk;
            if (r_warm < i_cfg.warmup_samples) begin
                n_warm = r_warm + WARM_W'(1);
            end else begin
                if (hit_lo && r_armed) begin
                    run_t   = (r_run == RUN_W'(RUN_MAX)) ? r_run : r_run + RUN_W'(1);
                    armed_t = 1'b1;
                end
                if (hit_hi) begin
                    armed_t = 1'b1;
                end
                if (run_t >= need) begin
                    n_beats    = (r_beats == BEAT_W'(BEAT_MAX)) ? r_beats
                                                                : r_beats + BEAT_W'(1);
                    run_t      = '0;
                    armed_t    = 1'b0;
                    n_out.beat = 1'b1;
                end
                n_run   = run_t;
                n_armed = armed_t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak      <= '0;
            r_warm      <= '0;
            r_armed     <= 1'b0;
            r_run       <= '0;
            r_beats     <= '0;
            r_hidx      <= '0;
            r_ticks     <= '0;
            r_hsum      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < HISTORY_WINDOWS; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            if (pop) begin
                r_peak  <= n_peak;
                r_warm  <= n_warm;
                r_armed <= n_armed;
                r_run   <= n_run;
                r_beats <= n_beats;
                r_hidx  <= n_hidx;
                r_ticks <= n_ticks;
                r_hsum  <= n_hsum;
                if (hist_we) begin
                    r_hist[r_hidx] <= r_beats;
                end
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ----- design/ecg_qrs_detector_rate_monitor_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Path: an accepted transaction is pushed into the queue, popped by the back and registered
//   in the back's output register before it shows at the output.
// Throughput: one item per cycle while the result side is ready; the front shifts the window and
//   forms Y3 combinationally and the back updates peak, detector and rate history on each pop.
// Reset (synchronous, active low): registers return to 60/130/251/4, window fill, peak, detector,
//   beat counts and history clear at once; no clearing pass, the block is ready the next cycle.
module ecg_qrs_detector_rate_monitor_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Input stream
    input  wire logic                                 i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    input  wire logic [eqrm_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,   // [15:0] sample
    input  wire logic                                 i_s_axis_tuser,   // [0] kind (1 = tick)
    // Result stream
    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    output logic [eqrm_pkg::OUT_TDATA_W-1:0]          o_m_axis_tdata,   // [0] beat, [19:1] feature,
                                                                        // [20] rate_valid,
                                                                        // [31:21] rate_bpm,
                                                                        // [32] slow_flag,
                                                                        // [33] fast_flag, rest zero
    // Configuration writes
    input  wire logic                                 i_cfg_we,
    input  wire logic [eqrm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [eqrm_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import eqrm_pkg::*;

    t_cfg    r_cfg;
    logic    cmd_valid;
    logic    cmd_ready;
    t_cmd    cmd;
    logic    q_valid;
    logic    q_ready;
    t_cmd    q_cmd;
    t_result res;

    // Configuration registers: write-only, taken on any edge with the enable high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_low       <= RATE_LOW_RST;
            r_cfg.rate_high      <= RATE_HIGH_RST;
            r_cfg.warmup_samples <= WARMUP_RST;
            r_cfg.run_length     <= RUN_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RATE_LOW:  r_cfg.rate_low       <= i_cfg_wdata[RATE_W-1:0];
                CFG_RATE_HIGH: r_cfg.rate_high      <= i_cfg_wdata[RATE_W-1:0];
                CFG_WARMUP:    r_cfg.warmup_samples <= i_cfg_wdata[WARM_W-1:0];
                CFG_RUN_LEN:   r_cfg.run_length     <= i_cfg_wdata[RUN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front: accept a transaction, shift the window, classify as tick, fill or computed sample
    eqrm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_kind      (i_s_axis_tuser),
        .i_sample    (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // Short queue: hold classified items so either side can stall on its own
    eqrm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (cmd_valid),
        .o_push_ready (cmd_ready),
        .i_push_cmd   (cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_cmd    (q_cmd)
    );

    // Back: peak tracking, arm/run detection, rate history; registered result
    eqrm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (res)
    );

    // Pad the packed result up to whole bytes
    assign o_m_axis_tdata = OUT_TDATA_W'(res);

endmodule

`default_nettype wire

// ----- test/ecg_qrs_detector_rate_monitor_unit_test.sv -----
`timescale 1ns / 1ps

module ecg_qrs_detector_rate_monitor_unit_test;
    import eqrm_pkg::*;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // Results that can be typed in directly
    localparam t_result ZERO_RESULT  = '0;
    localparam t_result SLOW_AT_ZERO = '{fast_flag: 1'b0, slow_flag: 1'b1, rate_bpm: '0,
                                         rate_valid: 1'b1, feature: '0, beat: 1'b0};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;      // [15:0] sample
    logic                   i_s_axis_tuser = 1'b0;    // [0] kind (1 = tick)
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;           // [0] beat, [19:1] feature,
                                                      // [20] rate_valid, [31:21] rate_bpm,
                                                      // [32] slow_flag, [33] fast_flag
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    ecg_qrs_detector_rate_monitor_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // Detector and rate state as the block should hold it
    logic [RATE_W-1:0]             cfg_rate_low   = RATE_LOW_RST;
    logic [RATE_W-1:0]             cfg_rate_high  = RATE_HIGH_RST;
    logic [WARM_W-1:0]             cfg_warmup     = WARMUP_RST;
    logic [RUN_W-1:0]              cfg_run_length = RUN_LEN_RST;
    logic signed [SAMPLE_BITS-1:0] ecg_window [WIN_LEN] = '{default: '0};
    int                            fill_level   = 0;
    int                            peak_level   = 0;
    int                            trained      = 0;
    bit                            armed        = 1'b0;
    int                            run_len      = 0;
    int                            window_beats = 0;
    int                            beat_hist [HISTORY_WINDOWS] = '{default: 0};
    int                            hist_slot    = 0;
    int                            ticks_seen   = 0;

    t_result pending_results [$];
    int      mismatch_count = 0;
    int      results_seen   = 0;

    // Idling knobs, set per phase by the stimulus process
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;

    // Synthetic ECG shape: square-wave QRS bursts over a quiet baseline
    int         burst_left = 0;
    int         base_left  = 0;
    int         ecg_amp    = 32767;
    logic [1:0] sq_phase   = '0;

    typedef struct packed {
        logic        kind;
        logic [15:0] smp;
        logic        typed;
        t_result     want;
    } t_directed_row;

    // Default registers (long warm-up), so no beat can fire here. Ticks land during fill,
    // a flat window gives zero feature, full-scale edges give the largest feature, and
    // the fifth tick on reports an empty history as slow.
    t_directed_row directed_rows [23] = '{
        '{KIND_TICK,   16'h0000, 1'b1, ZERO_RESULT},
        '{KIND_SAMPLE, 16'h8000, 1'b1, ZERO_RESULT},
        '{KIND_SAMPLE, 16'h8000, 1'b1, ZERO_RESULT},
        '{KIND_TICK,   16'h1234, 1'b1, ZERO_RESULT},
        '{KIND_SAMPLE, 16'h8000, 1'b1, ZERO_RESULT},
        '{KIND_SAMPLE, 16'h8000, 1'b1, ZERO_RESULT},
        '{KIND_SAMPLE, 16'h8000, 1'b1, ZERO_RESULT},
        '{KIND_SAMPLE, 16'h7FFF, 1'b0, ZERO_RESULT},
        '{KIND_SAMPLE, 16'h7FFF, 1'b0, ZERO_RESULT},
        '{KIND_SAMPLE, 16'h8000, 1'b0, ZERO_RESULT},
        '{KIND_SAMPLE, 16'h8000, 1'b0, ZERO_RESULT},
        '{KIND_SAMPLE, 16'h7FFF, 1'b0, ZERO_RESULT},
        '{KIND_SAMPLE, 16'h0000, 1'b0, ZERO_RESULT},
        '{KIND_SAMPLE, 16'h5555, 1'b0, ZERO_RESULT},
        '{KIND_SAMPLE, 16'hAAAA, 1'b0, ZERO_RESULT},
        '{KIND_SAMPLE, 16'h0001, 1'b0, ZERO_RESULT},
        '{KIND_SAMPLE, 16'hFFFF, 1'b0, ZERO_RESULT},
        '{KIND_TICK,   16'h0000, 1'b1, ZERO_RESULT},
        '{KIND_TICK,   16'h8000, 1'b1, ZERO_RESULT},
        '{KIND_TICK,   16'h7FFF, 1'b1, SLOW_AT_ZERO},
        '{KIND_TICK,   16'h0000, 1'b1, SLOW_AT_ZERO},
        '{KIND_SAMPLE, 16'h7FFF, 1'b0, ZERO_RESULT},
        '{KIND_TICK,   16'hFFFF, 1'b1, SLOW_AT_ZERO}
    };

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Advance the detector and rate state by one item and form its result
    task automatic predict_qrs_rate(input logic kind, input logic [15:0] smp,
                                    output t_result r);
        int x0, x1, x2, x3, x4;
        int y3, need, sum;
        r = '0;
        if (kind == KIND_SAMPLE) begin
            for (int i = 0; i < WIN_LEN - 1; i++) ecg_window[i] = ecg_window[i + 1];
            ecg_window[WIN_LEN - 1] = smp;
            if (fill_level < WIN_LEN - 1) begin
                fill_level++;
            end else begin
                x0 = ecg_window[0];
                x1 = ecg_window[1];
                x2 = ecg_window[2];
                x3 = ecg_window[3];
                x4 = ecg_window[4];
                y3 = magnitude(x2 - x0) + 2 * magnitude(x3 - x1) + magnitude(x4 - x2)
                   + magnitude(x0 - 2 * x2 + x4);
                if (y3 > FEAT_MAX) y3 = FEAT_MAX;
                r.feature = y3;
                if (y3 > peak_level) peak_level = y3;
                need = (cfg_run_length == 0) ? 1 : int'(cfg_run_length);
                if (trained < int'(cfg_warmup)) begin
                    trained++;
                end else begin
                    // Peak already includes this sample; thresholds compare exactly
                    if (10 * y3 >= peak_level && armed) begin
                        if (run_len < RUN_MAX) run_len++;
                    end else begin
                        run_len = 0;
                        armed   = 1'b0;
                    end
                    if (5 * y3 >= 4 * peak_level && !armed) armed = 1'b1;
                    if (run_len >= need) begin
                        if (window_beats < BEAT_MAX) window_beats++;
                        run_len = 0;
                        armed   = 1'b0;
                        r.beat  = 1'b1;
                    end
                end
            end
        end else begin
            if (hist_slot >= HISTORY_WINDOWS) hist_slot = 0;
            beat_hist[hist_slot] = window_beats;
            window_beats = 0;
            hist_slot = (hist_slot + 1 >= HISTORY_WINDOWS) ? 0 : hist_slot + 1;
            if (ticks_seen < HISTORY_WINDOWS - 1) begin
                ticks_seen++;
            end else begin
                sum = 0;
                foreach (beat_hist[h]) sum += beat_hist[h];
                sum *= RATE_SCALE;
                if (sum > BPM_MAX) sum = BPM_MAX;
                r.rate_valid = 1'b1;
                r.rate_bpm   = sum;
                if (sum <= int'(cfg_rate_low)) r.slow_flag = 1'b1;
                else if (sum >= int'(cfg_rate_high)) r.fast_flag = 1'b1;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("result %0d: %s got %0d, expected %0d", results_seen, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] d);
        t_result got;
        t_result want;
        got = d[OUT_BITS-1:0];
        results_seen++;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, bits", d[31:0], 0);
        end else begin
            want = pending_results.pop_front();
            if (got.beat !== want.beat) report_mismatch("beat", got.beat, want.beat);
            if (got.feature !== want.feature)
                report_mismatch("feature", got.feature, want.feature);
            if (got.rate_valid !== want.rate_valid)
                report_mismatch("rate_valid", got.rate_valid, want.rate_valid);
            if (got.rate_bpm !== want.rate_bpm)
                report_mismatch("rate_bpm", got.rate_bpm, want.rate_bpm);
            if (got.slow_flag !== want.slow_flag)
                report_mismatch("slow_flag", got.slow_flag, want.slow_flag);
            if (got.fast_flag !== want.fast_flag)
                report_mismatch("fast_flag", got.fast_flag, want.fast_flag);
            if (d[OUT_TDATA_W-1:OUT_BITS] !== '0)
                report_mismatch("padding", d[OUT_TDATA_W-1:OUT_BITS], 0);
        end
    endtask

    // Offer one item, hold it until accepted, then queue what it must produce.
    // A typed row replaces the computed expectation but still advances the state.
    task automatic send_item(input logic kind, input logic [15:0] smp,
                             input logic typed, input t_result want);
        t_result r;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= smp;
        i_s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_qrs_rate(kind, smp, r);
        pending_results.push_back(typed ? want : r);
    endtask

    // Drop valid and hold until every queued result is out
    task automatic wait_drain();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            CFG_RATE_LOW:  cfg_rate_low   = value;
            CFG_RATE_HIGH: cfg_rate_high  = value;
            CFG_WARMUP:    cfg_warmup     = value;
            CFG_RUN_LEN:   cfg_run_length = value;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One phase: drain, rewrite all registers, then stream n shaped random items.
    // The last few samples are forced into a strong burst so the next phase
    // starts with the detector in the middle of a run.
    task automatic run_phase(input int lo, input int hi, input int warm, input int run,
                             input int n, input int tx_idle, input int rx_stall,
                             input int tick_pct, input int hold, input bit pause_mid);
        int          pick, jit, level;
        logic        kind;
        logic [15:0] smp;
        wait_drain();
        write_reg(CFG_RATE_LOW, lo);
        write_reg(CFG_RATE_HIGH, hi);
        write_reg(CFG_WARMUP, warm);
        write_reg(CFG_RUN_LEN, run);
        tx_idle_pct  = tx_idle;
        rx_stall_pct = rx_stall;
        rx_hold_left = hold;
        for (int i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2) wait_drain();
            if (n >= 8 && i == n - 8) begin
                burst_left = 8;
                base_left  = 0;
                ecg_amp    = 32767;
            end
            pick = $urandom_range(99);
            if (pick < tick_pct) begin
                kind = KIND_TICK;
                smp  = 16'($urandom);
            end else if (pick < tick_pct + 4) begin
                // Noise sample anywhere in range
                kind = KIND_SAMPLE;
                smp  = 16'($urandom);
            end else begin
                kind = KIND_SAMPLE;
                if (burst_left == 0 && base_left == 0) begin
                    burst_left = $urandom_range(18, 2);
                    base_left  = $urandom_range(25, 1);
                    ecg_amp    = $urandom_range(32767, 20000);
                end
                if (burst_left > 0) begin
                    burst_left--;
                    jit   = $urandom_range(400);
                    level = sq_phase[1] ? ecg_amp - jit : jit - ecg_amp;
                    sq_phase++;
                end else begin
                    base_left--;
                    level = int'($urandom_range(2000)) - 1000;
                end
                smp = level[15:0];
            end
            send_item(kind, smp, 1'b0, ZERO_RESULT);
        end
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result side: check each accepted transaction, then pick next cycle's ready.
    // A requested hold-off is counted down here and wins over the random stall.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_m_axis_tvalid === 1'b1 && i_m_axis_tready)
                check_result(o_m_axis_tdata);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        int k;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows at reset settings, no idling
        foreach (directed_rows[r])
            send_item(directed_rows[r].kind, directed_rows[r].smp, directed_rows[r].typed,
                       directed_rows[r].want);

        // Detection on at once, shortest run; receiver holds off long enough that
        // the block fills and stalls its input
        run_phase(0, 255, 0, 1, 120, 0, 0, 4, 300, 1'b0);
        // Inverted thresholds, longest run, short extra warm-up, sparse sender
        run_phase(255, 0, 30, 15, 120, 64, 0, 4, 0, 1'b0);
        // Run length zero (acts as one) right after a long run; sender pauses midway
        run_phase(60, 130, 0, 0, 120, 0, 64, 4, 0, 1'b1);
        // Random thresholds, both sides idling
        run_phase($urandom_range(255), $urandom_range(255), 0, 3, 120, 21, 21, 4, 0, 1'b0);

        // Saturate the beat count: continuous full-scale bursts with no tick
        run_phase(30, 200, 0, 1, 0, 0, 0, 0, 0, 1'b0);
        repeat (2) begin
            for (k = 0; k < 132; k++)
                send_item(KIND_SAMPLE, k[1] ? 16'h7FFF : 16'h8000, 1'b0, ZERO_RESULT);
            send_item(KIND_TICK, 16'($urandom), 1'b0, ZERO_RESULT);
        end

        // Longest warm-up: detector trains only
        run_phase(100, 120, 1023, 2, 100, 21, 21, 6, 0, 1'b0);

        wait_drain();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
